[rtl/il2p_hdr_pkg.sv]
`default_nettype none

package il2p_hdr_pkg;

	localparam int HEADER_BYTES = 13;
	localparam int CALL_CHARS   = 6;
	localparam int POS_W        = $clog2(HEADER_BYTES);
	localparam int TDATA_W      = 144;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_TYPE0    = 2'd1;
	localparam logic [1:0] STATUS_BAD_DEST = 2'd2;
	localparam logic [1:0] STATUS_BAD_SRC  = 2'd3;

	localparam logic [3:0] KIND_U_BASE = 4'd4;
	localparam logic [3:0] KIND_UI     = 4'd9;
	localparam logic [3:0] KIND_I      = 4'd12;

	localparam logic [3:0] PID_S_FRAME = 4'd0;
	localparam logic [3:0] PID_U_FRAME = 4'd1;

	localparam logic [7:0] AX_PID_NONE = 8'hf0;

	typedef logic [HEADER_BYTES-1:0][7:0] hdr_bytes_t;
	typedef logic [CALL_CHARS-1:0][5:0] sixbit_call_t;

	typedef struct packed {
		logic        ok;
		logic [47:0] call;
	} call_dec_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [47:0] dest_call;
		logic [3:0]  dest_ssid;
		logic [47:0] src_call;
		logic [3:0]  source_ssid;
		logic [3:0]  frame_kind;
		logic        command_flag;
		logic        poll_final;
		logic [5:0]  sequence_pair;
		logic [7:0]  ax_pid;
		logic [9:0]  payload_count;
		logic        fec_level;
	} hdr_result_t;

	function automatic logic [7:0] pid_map(input logic [3:0] pid);
		logic [7:0] r;
		unique case (pid)
			4'h2:    r = 8'h20;
			4'h3:    r = 8'h01;
			4'h4:    r = 8'h06;
			4'h5:    r = 8'h07;
			4'h6:    r = 8'h08;
			4'hb:    r = 8'hcc;
			4'hc:    r = 8'hcd;
			4'hd:    r = 8'hce;
			4'he:    r = 8'hcf;
			default: r = AX_PID_NONE;
		endcase
		return r;
	endfunction

	// digits and upper-case letters in sixbit form
	function automatic logic char_ok(input logic [5:0] sx);
		return (sx >= 6'h10 && sx <= 6'h19) || (sx >= 6'h21 && sx <= 6'h3a);
	endfunction

	function automatic call_dec_t call_decode(input sixbit_call_t sx);
		call_dec_t  r;
		logic       keep;
		logic [6:0] ch;
		r.ok   = 1'b1;
		r.call = '0;
		keep   = 1'b0;
		for (int k = CALL_CHARS - 1; k >= 0; k--) begin
			keep = keep | (sx[k] != 6'd0);
			ch   = {1'b0, sx[k]} + 7'h20;
			if (keep) begin
				r.call[8*(CALL_CHARS-1-k) +: 8] = {1'b0, ch};
				if (!char_ok(sx[k])) begin
					r.ok = 1'b0;
				end
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/il2p_hdr_collect.sv]
`default_nettype none

module il2p_hdr_collect import il2p_hdr_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire logic [7:0] byte_in,
	input  wire logic       drain,
	output hdr_bytes_t      hdr_s1,
	output logic            valid_s1
);

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(HEADER_BYTES - 1);

	logic [POS_W-1:0]             pos_q;
	logic [HEADER_BYTES-2:0][7:0] line_q;
	logic                         done;

	assign done = take && (pos_q == LAST_POS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (take) begin
				pos_q <= done ? '0 : pos_q + POS_W'(1);
			end
			if (done) begin
				valid_s1 <= 1'b1;
			end else if (drain) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// byte i of the header ends up in entry i
	always_ff @(posedge clk) begin
		if (take && !done) begin
			line_q <= {byte_in, line_q[HEADER_BYTES-2:1]};
		end
		if (done) begin
			hdr_s1 <= {byte_in, line_q};
		end
	end

endmodule

`default_nettype wire

[rtl/il2p_hdr_decode.sv]
`default_nettype none

module il2p_hdr_decode import il2p_hdr_pkg::*; (
	input  wire hdr_bytes_t hdr,
	output hdr_result_t     res
);

	sixbit_call_t dest_sx;
	sixbit_call_t src_sx;
	call_dec_t    dest_dec;
	call_dec_t    src_dec;
	logic [9:0]   count;
	logic [3:0]   pid;
	logic [6:0]   ctl;
	logic         is_type1;

	always_comb begin
		for (int k = 0; k < CALL_CHARS; k++) begin
			dest_sx[k] = hdr[k][5:0];
			src_sx[k]  = hdr[CALL_CHARS+k][5:0];
		end
		for (int k = 0; k < 10; k++) begin
			count[9-k] = hdr[2+k][7];
		end
		for (int k = 0; k < 4; k++) begin
			pid[3-k] = hdr[1+k][6];
		end
		for (int k = 0; k < 7; k++) begin
			ctl[6-k] = hdr[5+k][6];
		end
	end

	assign is_type1 = hdr[1][7];
	assign dest_dec = call_decode(dest_sx);
	assign src_dec  = call_decode(src_sx);

	always_comb begin
		res               = '0;
		res.payload_count = count;
		res.fec_level     = hdr[0][7];
		priority if (!is_type1) begin
			res.status = STATUS_TYPE0;
		end else if (!dest_dec.ok) begin
			res.status = STATUS_BAD_DEST;
		end else if (!src_dec.ok) begin
			res.status = STATUS_BAD_SRC;
		end else begin
			res.status       = STATUS_OK;
			res.dest_call    = dest_dec.call;
			res.dest_ssid    = hdr[12][7:4];
			res.src_call     = src_dec.call;
			res.source_ssid  = hdr[12][3:0];
			res.poll_final   = ctl[6];
			res.command_flag = ctl[2];
			priority if (pid == PID_S_FRAME) begin
				res.frame_kind    = {2'b00, ctl[1:0]};
				res.sequence_pair = {ctl[5:3], 3'b000};
			end else if (pid == PID_U_FRAME) begin
				res.frame_kind = KIND_U_BASE + {1'b0, ctl[5:3]};
				if (res.frame_kind == KIND_UI) begin
					res.ax_pid = AX_PID_NONE;
				end
			end else if (hdr[0][6]) begin
				res.frame_kind = KIND_UI;
				res.ax_pid     = pid_map(pid);
			end else begin
				res.frame_kind    = KIND_I;
				res.command_flag  = 1'b1;
				res.sequence_pair = {ctl[5:3], ctl[2:0]};
				res.ax_pid        = pid_map(pid);
			end
		end
	end

endmodule

`default_nettype wire

[rtl/il2p_type1_header_decoder.sv]
// IL2P type 1 header decoder. Header bytes enter one per transaction on the
// slave side, positions 0 to 12 in order; every 13th byte completes a header
// and one decoded result transaction follows on the master side. A byte is
// taken every cycle unless backpressure stalls the input: the completed
// header sits in one register, is decoded by a single level of logic and
// lands in the output register; backpressure only stalls the input when
// both registers are full. Status 1 flags a type 0 header, 2 and 3 a bad
// destination or source character; in those cases only payload_count and
// fec_level carry data.
`default_nettype none

module il2p_type1_header_decoder import il2p_hdr_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [7:0]         s_tdata,  // header_byte[7:0]
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	// status[1:0], dest_call[49:2], dest_ssid[53:50], src_call[101:54],
	// source_ssid[105:102], frame_kind[109:106], command_flag[110],
	// poll_final[111], sequence_pair[117:112], ax_pid[125:118],
	// payload_count[135:126], fec_level[136], zero[143:137]
	output logic [TDATA_W-1:0]      m_tdata
);

	hdr_bytes_t  hdr_s1;
	logic        valid_s1;
	hdr_result_t res;
	logic        out_free;
	logic        drain;

	assign out_free = !m_tvalid || m_tready;
	assign drain    = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	il2p_hdr_collect u_collect (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (s_tvalid && s_tready),
		.byte_in  (s_tdata),
		.drain    (drain),
		.hdr_s1   (hdr_s1),
		.valid_s1 (valid_s1)
	);

	il2p_hdr_decode u_decode (
		.hdr (hdr_s1),
		.res (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			m_tdata <= {7'd0, res.fec_level, res.payload_count, res.ax_pid,
				res.sequence_pair, res.poll_final, res.command_flag, res.frame_kind,
				res.source_ssid, res.src_call, res.dest_ssid, res.dest_call, res.status};
		end
	end

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top import il2p_hdr_pkg::*; ();

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 150;

	localparam logic [5:0] SIXBIT_SPACE    = 6'h00;
	localparam logic [5:0] SIXBIT_DIGIT_0  = 6'h10;
	localparam logic [5:0] SIXBIT_LETTER_A = 6'h21;

	localparam logic [7:0] AX_PID_BY_PID [16] = '{
		8'hf0, 8'hf0, 8'h20, 8'h01, 8'h06, 8'h07, 8'h08, 8'hf0,
		8'hf0, 8'hf0, 8'hf0, 8'hcc, 8'hcd, 8'hce, 8'hcf, 8'hf0
	};

	typedef enum int {
		CALL_VALID,
		CALL_FULL,
		CALL_EMPTY,
		CALL_BAD_CHAR,
		CALL_INNER_SPACE
	} call_mode_e;

	typedef struct packed {
		logic         fec;
		logic         type1;
		logic [9:0]   count;
		logic         ui;
		logic [3:0]   pid;
		logic [6:0]   ctl;
		sixbit_call_t dest;
		sixbit_call_t src;
		logic [3:0]   dest_ssid;
		logic [3:0]   source_ssid;
	} hdr_fields_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;

	hdr_result_t expected_results[$];
	hdr_bytes_t  header_in_progress;
	int          byte_pos = 0;
	int          mismatch_count = 0;
	int          stall_cycles = 0;

	bit send_idle_on = 1'b0;
	bit recv_idle_on = 1'b0;
	int recv_hold_request = 0;
	int recv_hold_left = 0;
	int recv_burst_left = 0;

	il2p_type1_header_decoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	function automatic logic is_call_char(input logic [7:0] ch);
		return (ch >= "A" && ch <= "Z") || (ch >= "0" && ch <= "9");
	endfunction

	// trailing spaces trimmed to zero bytes, first char in the top byte
	function automatic logic decode_call(input sixbit_call_t sx, output logic [47:0] call);
		logic [7:0] ch;
		logic       ok;
		int         len;
		ok   = 1'b1;
		call = '0;
		len  = CALL_CHARS;
		while (len > 0 && sx[len-1] == SIXBIT_SPACE)
			len--;
		for (int k = 0; k < CALL_CHARS; k++) begin
			ch = {2'b00, sx[k]} + 8'h20;
			if (k < len) begin
				call[8*(CALL_CHARS-1-k) +: 8] = ch;
				if (!is_call_char(ch))
					ok = 1'b0;
			end
		end
		return ok;
	endfunction

	function automatic hdr_result_t decode_header(input hdr_bytes_t hb);
		hdr_result_t  r;
		sixbit_call_t dest_sx, src_sx;
		logic [47:0]  dest_call, src_call;
		logic [3:0]   pid;
		logic [6:0]   ctl;
		r = '0;
		r.fec_level = hb[0][7];
		for (int i = 0; i < 10; i++)
			r.payload_count[9-i] = hb[2+i][7];
		if (!hb[1][7]) begin
			r.status = STATUS_TYPE0;
			return r;
		end
		for (int k = 0; k < CALL_CHARS; k++) begin
			dest_sx[k] = hb[k][5:0];
			src_sx[k]  = hb[CALL_CHARS+k][5:0];
		end
		if (!decode_call(dest_sx, dest_call)) begin
			r.status = STATUS_BAD_DEST;
			return r;
		end
		if (!decode_call(src_sx, src_call)) begin
			r.status = STATUS_BAD_SRC;
			return r;
		end
		for (int i = 0; i < 4; i++)
			pid[3-i] = hb[1+i][6];
		for (int i = 0; i < 7; i++)
			ctl[6-i] = hb[5+i][6];
		r.status       = STATUS_OK;
		r.dest_call    = dest_call;
		r.dest_ssid    = hb[12][7:4];
		r.src_call     = src_call;
		r.source_ssid  = hb[12][3:0];
		r.poll_final   = ctl[6];
		r.command_flag = ctl[2];
		if (pid == PID_S_FRAME) begin
			r.frame_kind    = {2'b00, ctl[1:0]};
			r.sequence_pair = {ctl[5:3], 3'b000};
		end else if (pid == PID_U_FRAME) begin
			r.frame_kind = KIND_U_BASE + {1'b0, ctl[5:3]};
			if (r.frame_kind == KIND_UI)
				r.ax_pid = AX_PID_NONE;
		end else if (hb[0][6]) begin
			r.frame_kind = KIND_UI;
			r.ax_pid     = AX_PID_BY_PID[pid];
		end else begin
			r.frame_kind    = KIND_I;
			r.command_flag  = 1'b1;
			r.sequence_pair = ctl[5:0];
			r.ax_pid        = AX_PID_BY_PID[pid];
		end
		return r;
	endfunction

	function automatic sixbit_call_t random_call(input call_mode_e mode);
		sixbit_call_t sx;
		int           len;
		logic [5:0]   v;
		sx = '0;
		if (mode == CALL_EMPTY)
			return sx;
		if (mode == CALL_FULL)
			len = CALL_CHARS;
		else
			len = $urandom_range(mode == CALL_INNER_SPACE ? 2 : 1, CALL_CHARS);
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(0, 1))
				sx[k] = SIXBIT_DIGIT_0 + 6'($urandom_range(0, 9));
			else
				sx[k] = SIXBIT_LETTER_A + 6'($urandom_range(0, 25));
		end
		if (mode == CALL_BAD_CHAR) begin
			do
				v = 6'($urandom_range(1, 63));
			while (is_call_char({2'b00, v} + 8'h20));
			sx[$urandom_range(0, len - 1)] = v;
		end else if (mode == CALL_INNER_SPACE) begin
			sx[$urandom_range(0, len - 2)] = SIXBIT_SPACE;
		end
		return sx;
	endfunction

	function automatic hdr_fields_t random_fields();
		hdr_fields_t f;
		f.fec   = 1'($urandom_range(0, 1));
		f.type1 = 1'b1;
		f.count = 10'($urandom_range(0, 1023));
		f.ui    = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 3))
			0:       f.pid = PID_S_FRAME;
			1:       f.pid = PID_U_FRAME;
			default: f.pid = 4'($urandom_range(2, 15));
		endcase
		f.ctl         = 7'($urandom_range(0, 127));
		f.dest        = random_call($urandom_range(0, 9) == 0 ? CALL_EMPTY : CALL_VALID);
		f.src         = random_call($urandom_range(0, 9) == 0 ? CALL_EMPTY : CALL_VALID);
		f.dest_ssid   = 4'($urandom_range(0, 15));
		f.source_ssid = 4'($urandom_range(0, 15));
		return f;
	endfunction

	function automatic hdr_bytes_t build_header(input hdr_fields_t f);
		hdr_bytes_t hb;
		for (int k = 0; k < CALL_CHARS; k++) begin
			hb[k][5:0]            = f.dest[k];
			hb[CALL_CHARS+k][5:0] = f.src[k];
		end
		hb[0][7] = f.fec;
		hb[0][6] = f.ui;
		hb[1][7] = f.type1;
		for (int i = 0; i < 10; i++)
			hb[2+i][7] = f.count[9-i];
		for (int i = 0; i < 4; i++)
			hb[1+i][6] = f.pid[3-i];
		for (int i = 0; i < 7; i++)
			hb[5+i][6] = f.ctl[6-i];
		hb[12] = {f.dest_ssid, f.source_ssid};
		return hb;
	endfunction

	task automatic send_byte(input logic [7:0] value);
		if (send_idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	task automatic send_header(input hdr_bytes_t hb);
		for (int i = 0; i < HEADER_BYTES; i++)
			send_byte(hb[i]);
	endtask

	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [47:0] want,
			input logic [47:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// input monitor feeding the header decode
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			header_in_progress[byte_pos] = s_tdata;
			if (byte_pos == HEADER_BYTES - 1) begin
				expected_results.push_back(decode_header(header_in_progress));
				byte_pos = 0;
			end else begin
				byte_pos++;
			end
		end
	end

	always @(posedge clk) begin : result_check
		hdr_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result transaction, expected none, actual %h",
					$time, m_tdata);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("status", 48'(want.status), 48'(m_tdata[1:0]));
				check_field("dest_call", want.dest_call, m_tdata[49:2]);
				check_field("dest_ssid", 48'(want.dest_ssid), 48'(m_tdata[53:50]));
				check_field("src_call", want.src_call, m_tdata[101:54]);
				check_field("source_ssid", 48'(want.source_ssid), 48'(m_tdata[105:102]));
				check_field("frame_kind", 48'(want.frame_kind), 48'(m_tdata[109:106]));
				check_field("command_flag", 48'(want.command_flag), 48'(m_tdata[110]));
				check_field("poll_final", 48'(want.poll_final), 48'(m_tdata[111]));
				check_field("sequence_pair", 48'(want.sequence_pair),
					48'(m_tdata[117:112]));
				check_field("ax_pid", 48'(want.ax_pid), 48'(m_tdata[125:118]));
				check_field("payload_count", 48'(want.payload_count),
					48'(m_tdata[135:126]));
				check_field("fec_level", 48'(want.fec_level), 48'(m_tdata[136]));
			end
		end
	end

	always @(negedge clk) begin
		if (recv_hold_request > 0) begin
			recv_hold_left    = recv_hold_request;
			recv_hold_request = 0;
		end
		if (recv_hold_left > 0) begin
			recv_hold_left--;
			m_tready <= 1'b0;
		end else if (recv_burst_left > 0) begin
			recv_burst_left--;
			m_tready <= 1'b0;
		end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
			recv_burst_left = $urandom_range(1, 19) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic test_extremes();
		send_header({HEADER_BYTES{8'hff}});
		send_header({HEADER_BYTES{8'h00}});
	endtask

	task automatic test_frame_kinds();
		hdr_fields_t f;
		send_idle_on = 1'b1;
		recv_idle_on = 1'b1;
		for (int n = 0; n < 26; n++) begin
			f = random_fields();
			if (n < 4) begin
				f.pid      = PID_S_FRAME;
				f.ctl[1:0] = 2'(n);
			end else if (n < 12) begin
				f.pid      = PID_U_FRAME;
				f.ctl[5:3] = 3'(n - 4);
			end else begin
				f.pid = 4'($urandom_range(2, 15));
				f.ui  = (n < 19);
			end
			send_header(build_header(f));
		end
	endtask

	task automatic test_callsign_errors();
		hdr_fields_t f;
		for (int n = 0; n < 20; n++) begin
			f = random_fields();
			case (n % 10)
				0: f.dest = random_call(CALL_BAD_CHAR);
				1: f.dest = random_call(CALL_INNER_SPACE);
				2: f.src  = random_call(CALL_BAD_CHAR);
				3: f.src  = random_call(CALL_INNER_SPACE);
				4: begin
					f.dest = random_call(CALL_BAD_CHAR);
					f.src  = random_call(CALL_INNER_SPACE);
				end
				5: f.dest = random_call(CALL_EMPTY);
				6: f.src  = random_call(CALL_EMPTY);
				7: begin
					f.dest = random_call(CALL_EMPTY);
					f.src  = random_call(CALL_EMPTY);
				end
				8: begin
					f.type1 = 1'b0;
					f.dest  = random_call(CALL_BAD_CHAR);
				end
				default: begin
					f.dest = random_call(CALL_FULL);
					f.src  = random_call(CALL_FULL);
				end
			endcase
			send_header(build_header(f));
		end
	endtask

	// output held off long enough for the input to stall, then a full drain
	task automatic test_backpressure();
		hdr_fields_t f;
		wait_for_drain();
		send_idle_on = 1'b0;
		recv_idle_on = 1'b0;
		@(posedge clk);
		recv_hold_request = HOLD_CYCLES;
		@(negedge clk);
		for (int n = 0; n < 4; n++) begin
			f = random_fields();
			send_header(build_header(f));
		end
		wait_for_drain();
	endtask

	task automatic test_random_mix();
		hdr_fields_t f;
		hdr_bytes_t  hb;
		int          pick;
		for (int n = 0; n < 70; n++) begin
			if (n % 10 == 0) begin
				send_idle_on = ($urandom_range(0, 2) != 0);
				recv_idle_on = ($urandom_range(0, 2) != 0);
			end
			pick = $urandom_range(0, 99);
			f = random_fields();
			if (pick < 8) begin
				hb = (8 * HEADER_BYTES)'({$urandom, $urandom, $urandom, $urandom});
			end else begin
				if (pick < 14)
					f.type1 = 1'b0;
				else if (pick < 22)
					f.dest = random_call($urandom_range(0, 1) ? CALL_BAD_CHAR : CALL_INNER_SPACE);
				else if (pick < 30)
					f.src = random_call($urandom_range(0, 1) ? CALL_BAD_CHAR : CALL_INNER_SPACE);
				hb = build_header(f);
			end
			send_header(hb);
		end
	endtask

	task automatic test_steady_stream();
		send_idle_on = 1'b0;
		recv_idle_on = 1'b0;
		for (int n = 0; n < 16; n++)
			send_header(build_header(random_fields()));
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		test_extremes();
		test_frame_kinds();
		test_callsign_errors();
		test_backpressure();
		test_random_mix();
		test_steady_stream();
		wait_for_drain();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[filelist.f]
rtl/il2p_hdr_pkg.sv
rtl/il2p_hdr_collect.sv
rtl/il2p_hdr_decode.sv
rtl/il2p_type1_header_decoder.sv
verif/tb_top.sv
